[hw/rtl/wtig_pkg.sv]
// Shared types, field widths and register codes for the window tile index generator.
package wtig_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_GRID   = 1024;
  localparam int DEF_MAX_FRAMES = 256;
  localparam int DEF_INDEX_BITS = 24;
  localparam int DEF_MAX_WINDOW = 64;

  // Fixed widths of the input fields and the register
  localparam int FRAMES_W = 9;
  localparam int GRID_W   = 11;
  localparam int WSIZE_W  = 7;
  localparam int IN_DATA_W = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_WINDOW_SIZE = 1'b0;  // register index, paddr[2]
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 7'd32;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef struct packed {
    logic window_end;
    logic span_end;
    logic overflow;
  } token_flags_t;

endpackage

[hw/rtl/wtig_walker.sv]
// Span state and window-order walk: one token per step, incremental address arithmetic.
module wtig_walker
  import wtig_pkg::*;
#(
  parameter int MAX_GRID   = DEF_MAX_GRID,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  step,
  input  logic                  new_batch,
  input  logic [FRAMES_W-1:0]   frames,
  input  logic [GRID_W-1:0]     grid_h,
  input  logic [GRID_W-1:0]     grid_w,
  input  logic [WSIZE_W-1:0]    window_size,
  output logic                  emit,
  output logic [INDEX_BITS-1:0] token_index,
  output logic [INDEX_BITS-1:0] window_pos,
  output token_flags_t          flags
);

  localparam int GB = $clog2(MAX_GRID + 1);
  localparam int FB = $clog2(MAX_FRAMES + 1);
  localparam int WB = $clog2(MAX_WINDOW + 1);
  localparam int BW = ((INDEX_BITS > 2 * GB) ? INDEX_BITS : 2 * GB) + 1;
  localparam int SB = ((GB > WB) ? GB : WB) + 1;

  logic                  active;
  logic                  batch_over;
  logic [WB-1:0]         ws;
  logic [GB-1:0]         span_w, span_h;
  logic [FB-1:0]         span_frames, frame_cnt;
  logic [GB-1:0]         cur_row, cur_col, row0, col0, row_lim, col_lim;
  logic [BW-1:0]         row_base, win_base;
  logic [INDEX_BITS-1:0] frame_base, span_base, token_count;
  logic [2*GB-1:0]       frame_size;

  // load-side geometry, clamped
  logic [31:0]   t32, h32, w32, ws32;
  logic [FB-1:0] ld_frames;
  logic [GB-1:0] ld_h, ld_w;
  logic [WB-1:0] ld_ws;
  logic [INDEX_BITS-1:0] ld_base;

  // step-side signals
  logic [BW-1:0]         idx_full;
  logic                  col_last, row_last, win_end, band_last, frame_end, span_done;
  logic [SB-1:0]         col_adv_sum, row_adv_sum;
  logic [GB-1:0]         col_lim_adv, row_lim_adv, first_col_lim, first_row_lim;
  logic [BW-1:0]         frame_sum, row_base_inc;
  logic [INDEX_BITS:0]   tc_sum;
  logic [INDEX_BITS-1:0] fb_wrap;
  logic                  fb_over;

  always_comb begin
    t32  = 32'(frames);
    h32  = 32'(grid_h);
    w32  = 32'(grid_w);
    ws32 = 32'(window_size);
    ld_frames = (t32 > MAX_FRAMES) ? FB'(MAX_FRAMES) : FB'(t32);
    ld_h      = (h32 > MAX_GRID) ? GB'(MAX_GRID) : GB'(h32);
    ld_w      = (w32 > MAX_GRID) ? GB'(MAX_GRID) : GB'(w32);
    if (ws32 == 32'd0) begin
      ld_ws = WB'(1);
    end else if (ws32 > MAX_WINDOW) begin
      ld_ws = WB'(MAX_WINDOW);
    end else begin
      ld_ws = WB'(ws32);
    end
    ld_base = new_batch ? '0 : span_base;
  end

  always_comb begin
    idx_full  = row_base + BW'(cur_col);
    col_last  = (GB'(cur_col + GB'(1)) == col_lim);
    row_last  = (GB'(cur_row + GB'(1)) == row_lim);
    win_end   = col_last && row_last;
    band_last = (col_lim == span_w);
    frame_end = win_end && band_last && (row_lim == span_h);
    span_done = frame_end && (FB'(frame_cnt + FB'(1)) == span_frames);

    col_adv_sum = SB'(col_lim) + SB'(ws);
    row_adv_sum = SB'(row_lim) + SB'(ws);
    col_lim_adv = (col_adv_sum > SB'(span_w)) ? span_w : GB'(col_adv_sum);
    row_lim_adv = (row_adv_sum > SB'(span_h)) ? span_h : GB'(row_adv_sum);
    first_col_lim = (SB'(ws) > SB'(span_w)) ? span_w : GB'(ws);
    first_row_lim = (SB'(ws) > SB'(span_h)) ? span_h : GB'(ws);

    row_base_inc = row_base + BW'(span_w);
    frame_sum    = BW'(frame_base) + BW'(frame_size);
    fb_wrap      = frame_sum[INDEX_BITS-1:0];
    fb_over      = (frame_sum[BW-1:INDEX_BITS] != '0);
    tc_sum       = {1'b0, token_count} + {{INDEX_BITS{1'b0}}, 1'b1};

    emit        = step && active;
    token_index = idx_full[INDEX_BITS-1:0];
    window_pos  = token_count;
    flags.window_end = win_end;
    flags.span_end   = span_done;
    flags.overflow   = batch_over || (idx_full[BW-1:INDEX_BITS] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      batch_over  <= 1'b0;
      ws          <= '0;
      span_w      <= '0;
      span_h      <= '0;
      span_frames <= '0;
      frame_cnt   <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      row0        <= '0;
      col0        <= '0;
      row_lim     <= '0;
      col_lim     <= '0;
      row_base    <= '0;
      win_base    <= '0;
      frame_base  <= '0;
      span_base   <= '0;
      token_count <= '0;
      frame_size  <= '0;
    end else if (load) begin
      if (new_batch) begin
        span_base   <= '0;
        token_count <= '0;
        batch_over  <= 1'b0;
      end
      ws          <= ld_ws;
      span_w      <= ld_w;
      span_h      <= ld_h;
      span_frames <= ld_frames;
      frame_size  <= (2*GB)'(ld_h) * (2*GB)'(ld_w);
      frame_cnt   <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      row0        <= '0;
      col0        <= '0;
      col_lim     <= (SB'(ld_ws) > SB'(ld_w)) ? ld_w : GB'(ld_ws);
      row_lim     <= (SB'(ld_ws) > SB'(ld_h)) ? ld_h : GB'(ld_ws);
      frame_base  <= ld_base;
      row_base    <= BW'(ld_base);
      win_base    <= BW'(ld_base);
      active      <= (ld_frames != '0) && (ld_h != '0) && (ld_w != '0);
    end else if (emit) begin
      token_count <= tc_sum[INDEX_BITS-1:0];
      if (tc_sum[INDEX_BITS] || (frame_end && fb_over)) begin
        batch_over <= 1'b1;
      end
      if (!col_last) begin
        cur_col <= GB'(cur_col + GB'(1));
      end else if (!row_last) begin
        // next row inside the same window
        cur_col  <= col0;
        cur_row  <= GB'(cur_row + GB'(1));
        row_base <= row_base_inc;
      end else if (!band_last) begin
        // next window to the right, back to the window's top row
        col0     <= col_lim;
        cur_col  <= col_lim;
        col_lim  <= col_lim_adv;
        cur_row  <= row0;
        row_base <= win_base;
      end else if (!frame_end) begin
        // next band of windows
        row0     <= row_lim;
        cur_row  <= row_lim;
        row_lim  <= row_lim_adv;
        col0     <= '0;
        cur_col  <= '0;
        col_lim  <= first_col_lim;
        row_base <= row_base_inc;
        win_base <= row_base_inc;
      end else begin
        // next frame
        row0       <= '0;
        cur_row    <= '0;
        col0       <= '0;
        cur_col    <= '0;
        row_lim    <= first_row_lim;
        col_lim    <= first_col_lim;
        frame_base <= fb_wrap;
        row_base   <= BW'(fb_wrap);
        win_base   <= BW'(fb_wrap);
        if (span_done) begin
          frame_cnt <= '0;
          active    <= 1'b0;
          span_base <= fb_wrap;
        end else begin
          frame_cnt <= FB'(frame_cnt + FB'(1));
        end
      end
    end
  end

  a_col_in_window: assert property (@(posedge clk) disable iff (rst)
    active |-> (cur_col < col_lim) && (cur_col >= col0))
    else $error("column left its window");

  a_row_in_window: assert property (@(posedge clk) disable iff (rst)
    active |-> (cur_row < row_lim) && (cur_row >= row0))
    else $error("row left its window");

  a_window_width: assert property (@(posedge clk) disable iff (rst)
    active |-> (32'(col_lim) - 32'(col0)) <= 32'(ws))
    else $error("window wider than its side");

  a_span_closes: assert property (@(posedge clk) disable iff (rst)
    (emit && flags.span_end) |=> !active)
    else $error("span still pending after its last token");

  a_span_end_is_window_end: assert property (@(posedge clk) disable iff (rst)
    (emit && flags.span_end) |-> flags.window_end)
    else $error("span ended inside a window");

endmodule

[hw/rtl/window_tile_index_generator.sv]
// Top level: stream channels, configuration register and result register around the walker.
//
//  channel  | direction | handshake        | content
//  ---------+-----------+------------------+----------------------------------------------
//  s_*      | in        | s_tvalid/tready  | tuser=action, tdata=new_batch,frames,grid_h,grid_w
//  m_*      | out       | m_tvalid/tready  | tdata=token_index,window_pos,window_end,overflow;
//           |           |                  | tlast=span_end
//  apb      | in        | psel/penable     | window_size at byte address 0
//
// One transaction per cycle in each direction; a step leaves its token in the result
// register in the cycle after it is accepted. Loads and idle steps produce nothing.
// rst is synchronous and clears all span state; window_size returns to 32.
// While a token waits with m_tready low, s_tready drops and the input holds.
module window_tile_index_generator
  import wtig_pkg::*;
#(
  parameter int MAX_GRID   = DEF_MAX_GRID,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int OUT_DATA_W = ((2 * INDEX_BITS + 2 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // new_batch, frames[8:0], grid_h[10:0], grid_w[10:0]
  input  logic                  s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // token_index, window_pos, window_end, overflow
  output logic                  m_tlast,   // span_end
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                  in_accept;
  logic                  load, step;
  logic [WSIZE_W-1:0]    window_size;
  logic                  emit;
  logic [INDEX_BITS-1:0] token_index, window_pos;
  token_flags_t          flags;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign load = in_accept && (action_t'(s_tuser) == ACT_LOAD);
  assign step = in_accept && (action_t'(s_tuser) == ACT_STEP);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? CFG_DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE)) begin
      window_size <= pwdata[WSIZE_W-1:0];
    end
  end

  wtig_walker #(
    .MAX_GRID   (MAX_GRID),
    .MAX_FRAMES (MAX_FRAMES),
    .INDEX_BITS (INDEX_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .step        (step),
    .new_batch   (s_tdata[0]),
    .frames      (s_tdata[FRAMES_W:1]),
    .grid_h      (s_tdata[FRAMES_W+GRID_W:FRAMES_W+1]),
    .grid_w      (s_tdata[FRAMES_W+2*GRID_W:FRAMES_W+GRID_W+1]),
    .window_size (window_size),
    .emit        (emit),
    .token_index (token_index),
    .window_pos  (window_pos),
    .flags       (flags)
  );

  // result register: fill on emit, drain when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= OUT_DATA_W'({flags.overflow, flags.window_end, window_pos, token_index});
      m_tlast <= flags.span_end;
    end
  end

endmodule
